>>> hw/rtl/cmw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmw_pkg;

    // Field and register widths
    localparam int OFS_W   = 12;
    localparam int ACOL_W  = 10;
    localparam int HGT_W   = 11;
    localparam int SCALE_W = 4;

    // Default depth of the column offset store
    localparam int MAX_COLUMNS_DEF = 512;

    // Item commands
    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;

    // Register reset values
    localparam logic [ACOL_W-1:0]  ACTIVE_RST = 10'd320;
    localparam logic [HGT_W-1:0]   HEIGHT_RST = 11'd200;
    localparam logic [SCALE_W-1:0] SCALE_RST  = 4'd1;

    typedef struct packed {
        logic [ACOL_W-1:0]  active_columns;
        logic [HGT_W-1:0]   screen_height;
        logic [SCALE_W-1:0] row_scale;
    } t_cfg;

    // Remainder of a byte by three: 4 is 1 mod 3, so fold base-4 digits
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        logic [2:0] u;
        s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
        t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
        u = (t >= 3'd3) ? (t - 3'd3) : t;
        return (u == 3'd3) ? 2'd0 : u[1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cmw_col_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module cmw_col_engine #(
    parameter int MAX_COLUMNS = cmw_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire cmw_pkg::t_cfg i_cfg,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [1:0]   i_cmd,
    input  wire logic [8:0]   i_column,
    input  wire logic [9:0]   i_row,
    input  wire logic [7:0]   i_random_byte,
    input  wire logic [3:0]   i_tick_count,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic              o_wipe_done,
    output logic              o_source_screen,
    output logic [9:0]        o_source_row
);

    localparam int ACW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int OW  = cmw_pkg::OFS_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state               r_state;
    logic [ACW-1:0]       r_col;
    logic [3:0]           r_pass;
    logic [3:0]           r_ticks;
    logic                 r_moved;
    logic                 r_rmw_valid;
    logic [ACW-1:0]       r_rmw_addr;
    logic                 r_fwd;
    logic signed [OW-1:0] r_fwd_data;
    logic                 r_s1_valid;
    logic [1:0]           r_s1_cmd;
    logic [9:0]           r_s1_row;
    logic                 r_s1_colok;
    logic                 r_out_valid;
    logic                 r_wipe_done;
    logic                 r_src_screen;
    logic [9:0]           r_src_row;
    logic signed [4:0]    r_prev;

    logic signed [OW-1:0] mem [MAX_COLUMNS];
    logic signed [OW-1:0] r_mem_q;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_s1_adv;
    logic                 w_issue;
    logic                 w_col_ok;
    logic [ACW-1:0]       w_col_addr;
    logic [CW-1:0]        w_n;
    logic                 w_last_col;

    logic [1:0]           w_mod3;
    logic signed [5:0]    w_step;
    logic signed [5:0]    w_v;
    logic signed [9:0]    w_scaled;

    logic signed [OW-1:0] w_y;
    logic signed [OW:0]   w_y13;
    logic signed [OW:0]   w_h;
    logic                 w_neg;
    logic                 w_live;
    logic [4:0]           w_base;
    logic [8:0]           w_dy;
    logic signed [OW:0]   w_sum;
    logic signed [OW-1:0] w_new;

    logic                 w_mem_we;
    logic [ACW-1:0]       w_mem_waddr;
    logic signed [OW-1:0] w_mem_wdata;
    logic                 w_mem_re;
    logic [ACW-1:0]       w_mem_raddr;

    logic signed [OW-1:0] w_qy;
    logic signed [OW:0]   w_qy13;
    logic signed [OW:0]   w_r13;
    logic [OW:0]          w_qdiff;
    logic                 w_q_screen;
    logic [9:0]           w_q_row;

    // Handshake
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign o_in_ready = (r_state == ST_IDLE) && (!r_s1_valid || w_out_free);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_issue    = (r_state == ST_SWEEP);

    // Column address and sweep length
    assign w_col_ok   = (32'(i_column) < 32'(MAX_COLUMNS));
    assign w_col_addr = ACW'(i_column);
    assign w_n        = (32'(i_cfg.active_columns) < 32'(MAX_COLUMNS)) ?
                        CW'(i_cfg.active_columns) : CW'(MAX_COLUMNS);
    assign w_last_col = (CW'(r_col) == (w_n - CW'(1)));

    // Start offset of a column
    assign w_mod3 = cmw_pkg::mod3(i_random_byte);
    assign w_step = 6'(r_prev) + $signed({4'b0000, w_mod3}) - 6'sd1;

    always_comb begin
        if (i_column == 9'd0) begin
            w_v = -$signed({2'b00, i_random_byte[3:0]});
        end else if (w_step > 6'sd0) begin
            w_v = 6'sd0;
        end else if (w_step == -6'sd16) begin
            w_v = -6'sd15;
        end else begin
            w_v = w_step;
        end
    end

    assign w_scaled = 10'($signed(w_v[4:0])) * 10'($signed({1'b0, i_cfg.row_scale}));

    // Melt step of one column, with the write in flight forwarded
    assign w_y    = r_fwd ? r_fwd_data : r_mem_q;
    assign w_y13  = (OW+1)'(w_y);
    assign w_h    = $signed({2'b00, i_cfg.screen_height});
    assign w_neg  = w_y[OW-1];
    assign w_live = !w_neg && (w_y13 < w_h);
    assign w_base = (w_y[OW-2:4] == '0) ? ({1'b0, w_y[3:0]} + 5'd1) : 5'd8;
    assign w_dy   = 9'(w_base) * 9'(i_cfg.row_scale);
    assign w_sum  = w_y13 + $signed({4'b0000, w_dy});

    always_comb begin
        if (w_neg) begin
            w_new = w_y + OW'(1);
        end else if (w_live) begin
            w_new = (w_sum >= w_h) ? w_h[OW-1:0] : w_sum[OW-1:0];
        end else begin
            w_new = w_y;
        end
    end

    // Memory port selection
    assign w_mem_we    = r_rmw_valid ||
                         (w_accept && (i_cmd == cmw_pkg::CMD_INIT) && w_col_ok);
    assign w_mem_waddr = r_rmw_valid ? r_rmw_addr : w_col_addr;
    assign w_mem_wdata = r_rmw_valid ? w_new : OW'(w_scaled);
    assign w_mem_re    = w_issue || (w_accept && (i_cmd == cmw_pkg::CMD_QUERY));
    assign w_mem_raddr = w_issue ? r_col : w_col_addr;

    // Column offset store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_q <= mem[w_mem_raddr];
        end
    end

    // Pixel source of a query
    assign w_qy    = r_s1_colok ? r_mem_q : '0;
    assign w_qy13  = (OW+1)'(w_qy);
    assign w_r13   = $signed({3'b000, r_s1_row});
    assign w_qdiff = w_r13 - w_qy13;

    always_comb begin
        if (w_qy <= OW'(0)) begin
            w_q_screen = 1'b0;
            w_q_row    = r_s1_row;
        end else if (w_r13 < w_qy13) begin
            w_q_screen = 1'b1;
            w_q_row    = r_s1_row;
        end else begin
            w_q_screen = 1'b0;
            w_q_row    = w_qdiff[9:0];
        end
    end

    // Control, sweep and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rmw_valid <= 1'b0;
            r_fwd       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_moved     <= 1'b0;
            r_col       <= '0;
            r_pass      <= '0;
        end else begin
            // track the read-modify-write in flight
            r_rmw_valid <= w_issue;
            r_rmw_addr  <= r_col;
            r_fwd       <= w_issue && r_rmw_valid && (r_rmw_addr == r_col);
            r_fwd_data  <= w_new;
            if (r_rmw_valid && (w_neg || w_live)) begin
                r_moved <= 1'b1;
            end

            // hold or advance the query stage
            if (w_accept && (i_cmd != cmw_pkg::CMD_TICK)) begin
                r_s1_valid <= 1'b1;
                r_s1_cmd   <= i_cmd;
                r_s1_row   <= i_row;
                r_s1_colok <= w_col_ok;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            // output register
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
                r_wipe_done <= 1'b0;
                if (r_s1_cmd == cmw_pkg::CMD_QUERY) begin
                    r_src_screen <= w_q_screen;
                    r_src_row    <= w_q_row;
                end else begin
                    r_src_screen <= 1'b0;
                    r_src_row    <= '0;
                end
            end else if ((r_state == ST_FINISH) && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_wipe_done  <= !r_moved;
                r_src_screen <= 1'b0;
                r_src_row    <= '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_cmd == cmw_pkg::CMD_INIT)) begin
                        r_prev <= w_v[4:0];
                    end
                    if (w_accept && (i_cmd == cmw_pkg::CMD_TICK)) begin
                        r_ticks <= i_tick_count;
                        r_pass  <= '0;
                        r_col   <= '0;
                        r_moved <= 1'b0;
                        if ((w_n == '0) || (i_tick_count == 4'd0)) begin
                            r_state <= ST_FINISH;
                        end else begin
                            r_state <= ST_SWEEP;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (w_last_col) begin
                        r_col <= '0;
                        if (r_pass == (r_ticks - 4'd1)) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_pass <= r_pass + 4'd1;
                        end
                    end else begin
                        r_col <= r_col + ACW'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_wipe_done     = r_wipe_done;
    assign o_source_screen = r_src_screen;
    assign o_source_row    = r_src_row;

    // Forwarding only ever covers a write that is actually in flight
    a_fwd_has_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_rmw_valid)
        else $error("forwarded offset without a write in flight");

    // The sweep never shares the memory with a pending query
    a_rmw_no_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rmw_valid |-> !r_s1_valid)
        else $error("column sweep overlaps a query read");

    // The pass counter stays below the requested step count
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_pass < r_ticks))
        else $error("sweep pass beyond tick count");

    // A finished sweep delivers its result and frees the block
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINISH) && w_out_free) |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("tick result not delivered");

endmodule

`default_nettype wire

>>> hw/rtl/column_melt_wipe_compositor.sv
`timescale 1ns / 1ps
`default_nettype none

// Column melt wipe compositor. Init and query items go through at one per
// cycle while the output is not stalled; a query's answer passes through the
// query stage register and then the output register, an init's empty result
// likewise. A tick item reads, updates and writes back every active column
// offset through the single offset memory, one column per cycle, once per
// tick; the finish state then loads its result into the output register
// when free, and the next item is taken once the block is idle again. The
// offset memory is not cleared after reset: each column must be initialised
// before it is queried or swept. Configuration registers sit at byte
// addresses 0 (active_columns), 4 (screen_height) and 8 (row_scale); the user
// must write them only while idle, as the block itself does not enforce it.

module column_melt_wipe_compositor #(
    parameter int MAX_COLUMNS = cmw_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [8:0]  i_column,
    input  wire logic [9:0]  i_row,
    input  wire logic [7:0]  i_random_byte,
    input  wire logic [3:0]  i_tick_count,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_wipe_done,
    output logic             o_source_screen,
    output logic [9:0]       o_source_row
);

    logic [cmw_pkg::ACOL_W-1:0]  r_active_columns;
    logic [cmw_pkg::HGT_W-1:0]   r_screen_height;
    logic [cmw_pkg::SCALE_W-1:0] r_row_scale;
    logic                        w_cfg_write;
    cmw_pkg::t_cfg               w_cfg;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    // Register writes on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_columns <= cmw_pkg::ACTIVE_RST;
            r_screen_height  <= cmw_pkg::HEIGHT_RST;
            r_row_scale      <= cmw_pkg::SCALE_RST;
        end else if (w_cfg_write) begin
            case (paddr[3:2])
                cmw_pkg::REG_ACTIVE: r_active_columns <= pwdata[cmw_pkg::ACOL_W-1:0];
                cmw_pkg::REG_HEIGHT: r_screen_height  <= pwdata[cmw_pkg::HGT_W-1:0];
                cmw_pkg::REG_SCALE:  r_row_scale      <= pwdata[cmw_pkg::SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (paddr[3:2])
            cmw_pkg::REG_ACTIVE: prdata = 32'(r_active_columns);
            cmw_pkg::REG_HEIGHT: prdata = 32'(r_screen_height);
            cmw_pkg::REG_SCALE:  prdata = 32'(r_row_scale);
            default:             prdata = '0;
        endcase
    end

    assign w_cfg.active_columns = r_active_columns;
    assign w_cfg.screen_height  = r_screen_height;
    assign w_cfg.row_scale      = r_row_scale;

    cmw_col_engine #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_random_byte   (i_random_byte),
        .i_tick_count    (i_tick_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_wipe_done     (o_wipe_done),
        .o_source_screen (o_source_screen),
        .o_source_row    (o_source_row)
    );

endmodule

`default_nettype wire
